[sv/dcs_pkg.sv]
// Shared types, constants and helpers for the delimited column sum block.
// No dependencies; every other file depends on this package.
package dcs_pkg;

  localparam int SUM_WIDTH  = 32;
  localparam int FIELD_W    = 32;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELIM  = CFG_IDX_W'(1);

  localparam logic [7:0] TARGET_RESET = 8'd5;
  localparam logic [7:0] DELIM_RESET  = 8'd124;
  localparam logic [7:0] TARGET_MIN   = 8'd2;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // classified byte, as queued between front and back
  typedef struct packed {
    logic       last;
    logic       is_delim;
    logic       is_newline;
    logic       is_digit;
    logic       is_blank;
    logic       is_sign;
    logic       is_minus;
    logic [3:0] digit;
  } tok_t;

  // end-of-stream snapshot handed to the result stage
  typedef struct packed {
    logic [SUM_WIDTH-1:0] total;
    logic [FIELD_W-1:0]   field;
    logic                 neg;
    logic                 incl;
    logic                 err;
  } res_t;

  // field value with its sign applied, sign-extended or cut to the sum width
  function automatic logic [SUM_WIDTH-1:0] signed_field(logic [FIELD_W-1:0] field,
                                                        logic neg);
    logic [FIELD_W-1:0] v;
    logic [63:0]        ext;
    v   = neg ? (FIELD_W'(0) - field) : field;
    ext = {{(64-FIELD_W){v[FIELD_W-1]}}, v};
    return ext[SUM_WIDTH-1:0];
  endfunction

  // low output bits of the sum, zero-filled when the sum is narrower
  function automatic logic [OUT_W-1:0] to_out(logic [SUM_WIDTH-1:0] total);
    logic [63:0] z;
    z = 64'(total);
    return z[OUT_W-1:0];
  endfunction

endpackage

[sv/dcs_ifs.sv]
// Channel interfaces: byte input, result output and configuration write.
// Depends on dcs_pkg for widths.
interface dcs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;
  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface dcs_sum_if;
  logic                                valid;
  logic                                ready;
  logic signed [dcs_pkg::OUT_W-1:0]    column_total;
  logic                                malformed;
  modport source (output valid, output column_total, output malformed, input ready);
  modport sink   (input valid, input column_total, input malformed, output ready);
endinterface

interface dcs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dcs_pkg::CFG_IDX_W-1:0]   index;
  logic [7:0]                      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/dcs_front.sv]
// Front end: configuration registers and byte classification into tokens.
// Depends on dcs_pkg and dcs_ifs.
module dcs_front (
  input  logic          clk,
  input  logic          rst_n,
  dcs_byte_if.sink      in_ch,
  dcs_cfg_if.sink       cfg_ch,
  output logic [7:0]    target_column,
  output logic          push_valid,
  output dcs_pkg::tok_t push_tok,
  input  logic          push_ready
);
  import dcs_pkg::*;

  logic [7:0] target_r;
  logic [7:0] delim_r;
  logic [7:0] b;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      delim_r  <= DELIM_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_TARGET) target_r <= cfg_ch.data;
      if (cfg_ch.index == REG_DELIM)  delim_r  <= cfg_ch.data;
    end
  end

  assign target_column = target_r;
  assign b             = in_ch.data_byte;
  assign push_valid    = in_ch.valid;
  assign in_ch.ready   = push_ready;

  always_comb begin
    push_tok            = '0;
    push_tok.last       = in_ch.stream_end;
    push_tok.is_delim   = (b == delim_r);
    push_tok.is_newline = (b == CH_NEWLINE);
    push_tok.is_digit   = b inside {[CH_ZERO:CH_NINE]};
    push_tok.is_blank   = (b == CH_SPACE) || (b == CH_TAB);
    push_tok.is_sign    = (b == CH_PLUS) || (b == CH_MINUS);
    push_tok.is_minus   = (b == CH_MINUS);
    push_tok.digit      = b[3:0];
  end

endmodule

[sv/dcs_fifo.sv]
// Short token queue between the front end and the parser.
// Depends on dcs_pkg.
module dcs_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  dcs_pkg::tok_t push_tok,
  output logic          push_ready,
  output logic          pop_valid,
  output dcs_pkg::tok_t pop_tok,
  input  logic          pop_ready
);
  import dcs_pkg::*;

  tok_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  do_push, do_pop;

  assign push_ready = (cnt_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_tok    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (!do_push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[sv/dcs_back.sv]
// Parser: column counting, atoi-style field parse and running total.
// Depends on dcs_pkg; fed by dcs_fifo, feeds dcs_result.
module dcs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    target_column,
  input  logic          tok_valid,
  input  dcs_pkg::tok_t tok,
  output logic          tok_ready,
  output logic          res_valid,
  output dcs_pkg::res_t res,
  input  logic          res_ready
);
  import dcs_pkg::*;

  localparam logic [1:0] PH_COUNT  = 2'd0;
  localparam logic [1:0] PH_LEAD   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  logic [1:0]           phase_r, phase_nxt;
  logic [7:0]           col_r, col_nxt, col_inc, target;
  logic                 neg_r, neg_nxt;
  logic [FIELD_W-1:0]   field_r, field_nxt, field_x10;
  logic [SUM_WIDTH-1:0] total_r, total_nxt;
  logic                 err_r, err_nxt;
  logic                 take;

  // a last beat waits until the result stage has room
  assign tok_ready = !tok.last || res_ready;
  assign take      = tok_valid && tok_ready;

  assign target    = (target_column < TARGET_MIN) ? TARGET_MIN : target_column;
  assign col_inc   = col_r + 8'd1;
  assign field_x10 = {field_r[FIELD_W-4:0], 3'b000} + {field_r[FIELD_W-2:0], 1'b0};

  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    neg_nxt   = neg_r;
    field_nxt = field_r;
    total_nxt = total_r;
    err_nxt   = err_r;
    case (phase_r)
      PH_COUNT: begin
        if (tok.is_delim) begin
          col_nxt = col_inc;
          if (col_inc >= target) begin
            phase_nxt = PH_LEAD;
            field_nxt = '0;
            neg_nxt   = 1'b0;
          end
        end else if (tok.is_newline) begin
          err_nxt = 1'b1;
          col_nxt = 8'd1;
        end
      end
      PH_LEAD, PH_DIGITS: begin
        if (tok.is_digit) begin
          field_nxt = field_x10 + FIELD_W'(tok.digit);
          phase_nxt = PH_DIGITS;
        end else if (phase_r == PH_LEAD && tok.is_blank) begin
          phase_nxt = PH_LEAD;
        end else if (phase_r == PH_LEAD && tok.is_sign) begin
          neg_nxt   = tok.is_minus;
          phase_nxt = PH_DIGITS;
        end else begin
          total_nxt = total_r + signed_field(field_r, neg_r);
          field_nxt = '0;
          neg_nxt   = 1'b0;
          col_nxt   = 8'd1;
          phase_nxt = tok.is_newline ? PH_COUNT : PH_SKIP;
        end
      end
      default: begin
        if (tok.is_newline) begin
          phase_nxt = PH_COUNT;
          col_nxt   = 8'd1;
        end
      end
    endcase
  end

  // snapshot after this beat; the open field is added in the result stage
  always_comb begin
    res.total = total_nxt;
    res.field = field_nxt;
    res.neg   = neg_nxt;
    res.incl  = (phase_nxt == PH_LEAD) || (phase_nxt == PH_DIGITS);
    res.err   = err_nxt;
  end
  assign res_valid = take && tok.last;

  always_ff @(posedge clk) begin
    if (!rst_n || (take && tok.last)) begin
      phase_r <= PH_COUNT;
      col_r   <= 8'd1;
      neg_r   <= 1'b0;
      field_r <= '0;
      total_r <= '0;
      err_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      neg_r   <= neg_nxt;
      field_r <= field_nxt;
      total_r <= total_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

[sv/dcs_result.sv]
// Result stage: holds the end-of-stream snapshot, adds the open field,
// drives the output register. Depends on dcs_pkg and dcs_ifs.
module dcs_result (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  dcs_pkg::res_t res,
  output logic          res_ready,
  dcs_sum_if.source     out_ch
);
  import dcs_pkg::*;

  logic                 fin_valid_r;
  res_t                 fin_r;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_total_r;
  logic                 out_err_r;
  logic                 out_ld;
  logic [SUM_WIDTH-1:0] sum;

  assign out_ld    = fin_valid_r && (!out_valid_r || out_ch.ready);
  assign res_ready = !fin_valid_r || out_ld;
  assign sum       = fin_r.total + (fin_r.incl ? signed_field(fin_r.field, fin_r.neg)
                                               : SUM_WIDTH'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid)   fin_valid_r <= 1'b1;
      else if (out_ld) fin_valid_r <= 1'b0;
      if (out_ld)                    out_valid_r <= 1'b1;
      else if (out_ch.ready)         out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) fin_r <= res;
    if (out_ld) begin
      out_total_r <= to_out(sum);
      out_err_r   <= fin_r.err;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.column_total = signed'(out_total_r);
  assign out_ch.malformed    = out_err_r;

endmodule

[sv/delimited_column_sum.sv]
// Top level of the delimited column sum block: front end, token queue,
// parser and result stage. Depends on dcs_pkg, dcs_ifs and the dcs_* modules.
//
//   channel  dir  payload                      beat when
//   in_ch    in   data_byte[7:0], stream_end   valid && ready
//   out_ch   out  column_total[31:0], malformed valid && ready
//   cfg_ch   in   index[7:0], data[7:0]        valid && ready (ready is always 1)
//
// One byte per cycle sustained unless out_ch stalls; the parser takes a token
// per cycle from a four-entry queue (a last token waits for room in the result
// stage), so in_ch.ready drops only when the queue fills. A result passes the
// queue, the snapshot register and the output register to reach out_ch. Reset
// clears control state; there is no clearing pass. A stalled out_ch holds one
// result plus one in the result stage; a further last byte waits in the queue.
module delimited_column_sum (
  input  logic      clk,
  input  logic      rst_n,
  dcs_byte_if.sink  in_ch,
  dcs_sum_if.source out_ch,
  dcs_cfg_if.sink   cfg_ch
);
  import dcs_pkg::*;

  logic       push_valid, push_ready;
  tok_t       push_tok;
  logic       pop_valid, pop_ready;
  tok_t       pop_tok;
  logic [7:0] target_column;
  logic       res_valid, res_ready;
  res_t       res;

  dcs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .cfg_ch        (cfg_ch),
    .target_column (target_column),
    .push_valid    (push_valid),
    .push_tok      (push_tok),
    .push_ready    (push_ready)
  );

  dcs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_tok   (push_tok),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_tok    (pop_tok),
    .pop_ready  (pop_ready)
  );

  dcs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .target_column (target_column),
    .tok_valid     (pop_valid),
    .tok           (pop_tok),
    .tok_ready     (pop_ready),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

  dcs_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule

[sv/dcs_checker.sv]
// Port-level checks for delimited_column_sum, attached by bind.
// Depends on dcs_pkg for the output width.
module dcs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dcs_pkg::OUT_W-1:0]  out_total,
  input logic                       out_malformed
);
  import dcs_pkg::*;

  // last beats taken in minus results delivered
  logic [3:0] pend_r;
  logic       last_in, res_out;

  assign last_in = in_valid && in_ready && in_last;
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else if (last_in && !res_out) pend_r <= pend_r + 1'b1;
    else if (!last_in && res_out) pend_r <= pend_r - 1'b1;
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a pending last beat");

  a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_total) && $stable(out_malformed))
    else $error("output payload changed while stalled");

endmodule

bind delimited_column_sum dcs_checker u_dcs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_last       (in_ch.stream_end),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_total     (out_ch.column_total),
  .out_malformed (out_ch.malformed)
);
